// ----- src/slpo_pkg.sv -----
// shared constants, types and register codes for the slab page order selector
// no dependencies; the rtl files refer to it by scoped names, the bench imports it
package slpo_pkg;

    localparam int PAGE_BITS            = 12;
    localparam int ORDER_LIMIT          = 11;
    localparam int MAX_OBJECTS_PER_SLAB = 32767;

    localparam int OBJ_W  = 24;
    localparam int RES_W  = 12;
    localparam int ORD_W  = 4;
    localparam int OBJS_W = 8;
    localparam int CPU_W  = 13;

    localparam int NUM_ORDERS = 1 << ORD_W;
    localparam int DIV_W      = PAGE_BITS + NUM_ORDERS;
    localparam int DCNT_W     = $clog2(DIV_W + 1);
    localparam int QUO_W      = $clog2(MAX_OBJECTS_PER_SLAB + 2);
    localparam int MAXO_W     = $clog2(MAX_OBJECTS_PER_SLAB + 1);
    localparam int PROD_W     = OBJ_W + MAXO_W;
    localparam int SCAN_W     = PROD_W - PAGE_BITS;
    localparam int HB_W       = $clog2(SCAN_W + 1);
    localparam int FLS_W      = $clog2(CPU_W + 1);

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int IN_TDATA_W  = ((OBJ_W + RES_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ORD_W + 7) / 8) * 8;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    localparam t_cfg_addr REG_MIN_ORDER = 2'd0;
    localparam t_cfg_addr REG_MAX_ORDER = 2'd1;
    localparam t_cfg_addr REG_MIN_OBJS  = 2'd2;
    localparam t_cfg_addr REG_CPU_COUNT = 2'd3;

    // waste grade of one order: lowest limit of 1/16, 1/8, 1/4 that it meets
    typedef logic [1:0] t_grade;
    localparam t_grade GRADE_16  = 2'd0;
    localparam t_grade GRADE_8   = 2'd1;
    localparam t_grade GRADE_4   = 2'd2;
    localparam t_grade GRADE_ANY = 2'd3;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DCNT_W-1:0] nbits;
        logic [OBJ_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quo;
        logic [OBJ_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [OBJ_W-1:0] size;
    } t_dir_req;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [HB_W-1:0] order;
    } t_dir_rsp;

endpackage

// ----- src/slpo_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle, saturating quotient
// depends on slpo_pkg
module slpo_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slpo_pkg::t_div_req i_req,
    output slpo_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic                          r_sat;
    logic [slpo_pkg::DCNT_W-1:0]   r_cnt;
    logic [slpo_pkg::DIV_W-1:0]    r_num;
    logic [slpo_pkg::OBJ_W-1:0]    r_rem;
    logic [slpo_pkg::OBJ_W-1:0]    r_div;
    logic [slpo_pkg::QUO_W-1:0]    r_quo;
    logic [slpo_pkg::OBJ_W-1:0]    n_rem;
    logic [slpo_pkg::OBJ_W:0]      trial;
    logic [slpo_pkg::OBJ_W:0]      diff;
    logic                          take;

    always_comb begin
        trial = {r_rem, r_num[slpo_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_div};
        take  = trial >= {1'b0, r_div};
        n_rem = take ? diff[slpo_pkg::OBJ_W-1:0] : trial[slpo_pkg::OBJ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == slpo_pkg::DCNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_cnt <= i_req.nbits;
            r_div <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[slpo_pkg::DIV_W-2:0], 1'b0};
            r_cnt <= r_cnt - slpo_pkg::DCNT_W'(1);
            r_rem <= n_rem;
            r_quo <= {r_quo[slpo_pkg::QUO_W-2:0], take};
            r_sat <= r_sat | r_quo[slpo_pkg::QUO_W-1];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_sat ? '1 : r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- src/slpo_direct.sv -----
// direct order for very small objects: size times the object limit, then a
// bit-serial scan for the highest set page bit; depends on slpo_pkg
module slpo_direct (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slpo_pkg::t_dir_req i_req,
    output slpo_pkg::t_dir_rsp o_rsp
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_SCAN = 2'd2;

    logic [1:0]                   r_phase;
    logic                         r_done;
    logic [slpo_pkg::PROD_W-1:0]  r_prod;
    logic [slpo_pkg::SCAN_W-1:0]  r_x;
    logic [slpo_pkg::HB_W-1:0]    r_h;
    logic [slpo_pkg::HB_W-1:0]    r_order;
    logic [slpo_pkg::PROD_W-1:0]  prod_m1;

    assign prod_m1 = r_prod - slpo_pkg::PROD_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                P_IDLE: begin
                    if (i_req.start) begin
                        r_phase <= P_MUL;
                    end
                end
                P_MUL: begin
                    r_phase <= P_SCAN;
                end
                P_SCAN: begin
                    if (r_x == '0) begin
                        r_phase <= P_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            P_IDLE: begin
                r_prod <= slpo_pkg::PROD_W'(i_req.size)
                        * slpo_pkg::PROD_W'(slpo_pkg::MAX_OBJECTS_PER_SLAB);
            end
            P_MUL: begin
                r_x <= prod_m1[slpo_pkg::PROD_W-1:slpo_pkg::PAGE_BITS];
                r_h <= '0;
            end
            P_SCAN: begin
                if (r_x == '0) begin
                    r_order <= (r_h == '0) ? '0 : r_h - slpo_pkg::HB_W'(1);
                end else begin
                    r_x <= r_x >> 1;
                    r_h <= r_h + slpo_pkg::HB_W'(1);
                end
            end
            default: begin
                r_h <= '0;
            end
        endcase
    end

    assign o_rsp.busy  = (r_phase != P_IDLE);
    assign o_rsp.done  = r_done;
    assign o_rsp.order = r_order;

endmodule

// ----- src/slab_page_order_select.sv -----
// slab page order selector: sequencer, per-order tables and stream ports
// depends on slpo_pkg, slpo_div and slpo_direct
//
//  channel   signals                                    moves
//  s_axis    tvalid tready tdata[39:0]                  request: object and reserved bytes
//  m_axis    tvalid tready tdata[7:0] tuser             result: page order, no-fit flag
//  cfg       i_cfg_valid o_cfg_ready i_cfg_addr/data    register write, always ready
//
// each request of nonzero size runs the serial divider once for every order from
// min(lo, top) up to max(lo, top, 10), then scans the per-order tables, runs the
// direct-order unit or picks the fallback order
// reset restores the register defaults and empties the result register
// a finished result waits in the output register; a new request is taken meanwhile
module slab_page_order_select (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // object_bytes [23:0], reserved_bytes [35:24]
    input  logic [slpo_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // page_order [3:0]
    output logic [slpo_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // no_fit [0]
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  slpo_pkg::t_cfg_addr                 i_cfg_addr,
    input  logic [slpo_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DIRECT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]                   r_state;

    logic [slpo_pkg::ORD_W-1:0]   r_min_order;
    logic [slpo_pkg::ORD_W-1:0]   r_max_order;
    logic [slpo_pkg::OBJS_W-1:0]  r_min_objs;
    logic [slpo_pkg::CPU_W-1:0]   r_cpu_count;

    logic [slpo_pkg::OBJ_W-1:0]   r_size;
    logic [slpo_pkg::RES_W-1:0]   r_res;
    logic [slpo_pkg::OBJS_W-1:0]  r_count0;
    logic [slpo_pkg::OBJS_W-1:0]  r_cstar;
    logic [slpo_pkg::ORD_W-1:0]   r_ord;
    logic [slpo_pkg::ORD_W-1:0]   r_end;
    logic                         r_div_start;
    logic                         r_dir_start;
    logic                         r_dir;
    logic [slpo_pkg::QUO_W-1:0]   r_maxq;
    logic                         r_m_found;
    logic [slpo_pkg::ORD_W-1:0]   r_m;
    slpo_pkg::t_grade             r_best_g;
    logic [slpo_pkg::ORD_W-1:0]   r_best_o;
    logic [slpo_pkg::ORD_W-1:0]   r_res_order;
    logic                         r_res_nofit;

    logic                         r_out_valid;
    logic [slpo_pkg::ORD_W-1:0]   r_out_order;
    logic                         r_out_nofit;

    logic [slpo_pkg::QUO_W-1:0]   r_q_tab [slpo_pkg::NUM_ORDERS];
    slpo_pkg::t_grade             r_g_tab [slpo_pkg::NUM_ORDERS];

    slpo_pkg::t_div_req           div_req;
    slpo_pkg::t_div_rsp           div_rsp;
    slpo_pkg::t_dir_req           dir_req;
    slpo_pkg::t_dir_rsp           dir_rsp;

    logic [slpo_pkg::OBJ_W-1:0]   in_size;
    logic [slpo_pkg::RES_W-1:0]   in_res;
    logic [slpo_pkg::FLS_W-1:0]   cpu_fls;
    logic [slpo_pkg::OBJS_W-1:0]  count0;
    logic [slpo_pkg::ORD_W-1:0]   first_ord;
    logic [slpo_pkg::ORD_W-1:0]   last_ord;
    logic [slpo_pkg::DIV_W-1:0]   rem_ext;
    logic [slpo_pkg::DIV_W-1:0]   thr_16;
    logic [slpo_pkg::DIV_W-1:0]   thr_8;
    logic [slpo_pkg::DIV_W-1:0]   thr_4;
    slpo_pkg::t_grade             grade;
    logic                         in_main;
    logic [slpo_pkg::QUO_W-1:0]   q_rd;
    slpo_pkg::t_grade             g_rd;
    logic                         scan_hit;
    logic [slpo_pkg::ORD_W-1:0]   scan_pick;
    logic [slpo_pkg::OBJS_W-1:0]  n_cstar;
    logic                         fall_ok;
    logic                         dir_ok;
    logic                         out_load;

    assign in_size = s_axis_tdata[slpo_pkg::OBJ_W-1:0];
    assign in_res  = s_axis_tdata[slpo_pkg::OBJ_W+slpo_pkg::RES_W-1:slpo_pkg::OBJ_W];

    // object count: min_objs if set, else a default from the processor count
    always_comb begin
        cpu_fls = '0;
        for (int i = 0; i < slpo_pkg::CPU_W; i++) begin
            if (r_cpu_count[i]) begin
                cpu_fls = slpo_pkg::FLS_W'(i + 1);
            end
        end
        if (r_min_objs != '0) begin
            count0 = r_min_objs;
        end else begin
            count0 = (slpo_pkg::OBJS_W'(cpu_fls) + slpo_pkg::OBJS_W'(1)) << 2;
        end
    end

    always_comb begin
        first_ord = (r_min_order < r_max_order) ? r_min_order : r_max_order;
        last_ord  = slpo_pkg::ORD_W'(slpo_pkg::ORDER_LIMIT - 1);
        if (r_max_order > last_ord) begin
            last_ord = r_max_order;
        end
        if (r_min_order > last_ord) begin
            last_ord = r_min_order;
        end
    end

    // slab minus reserved bytes, left aligned for the serial divider
    always_comb begin
        div_req.start    = r_div_start;
        div_req.dividend = {1'b1, {(slpo_pkg::DIV_W-1){1'b0}}}
                         - (slpo_pkg::DIV_W'(r_res)
                            << (slpo_pkg::ORD_W'(slpo_pkg::NUM_ORDERS - 1) - r_ord));
        div_req.nbits    = slpo_pkg::DCNT_W'(slpo_pkg::PAGE_BITS)
                         + slpo_pkg::DCNT_W'(r_ord) + slpo_pkg::DCNT_W'(1);
        div_req.divisor  = r_size;
        dir_req.start    = r_dir_start;
        dir_req.size     = r_size;
    end

    // waste limits are the slab shifted right by four, three and two
    always_comb begin
        rem_ext = slpo_pkg::DIV_W'(div_rsp.rem);
        thr_16  = slpo_pkg::DIV_W'(1) << (slpo_pkg::DCNT_W'(slpo_pkg::PAGE_BITS - 4)
                                          + slpo_pkg::DCNT_W'(r_ord));
        thr_8   = slpo_pkg::DIV_W'(1) << (slpo_pkg::DCNT_W'(slpo_pkg::PAGE_BITS - 3)
                                          + slpo_pkg::DCNT_W'(r_ord));
        thr_4   = slpo_pkg::DIV_W'(1) << (slpo_pkg::DCNT_W'(slpo_pkg::PAGE_BITS - 2)
                                          + slpo_pkg::DCNT_W'(r_ord));
        if (rem_ext <= thr_16) begin
            grade = slpo_pkg::GRADE_16;
        end else if (rem_ext <= thr_8) begin
            grade = slpo_pkg::GRADE_8;
        end else if (rem_ext <= thr_4) begin
            grade = slpo_pkg::GRADE_4;
        end else begin
            grade = slpo_pkg::GRADE_ANY;
        end
        in_main = (r_ord >= r_min_order) && (r_ord <= r_max_order);
    end

    always_comb begin
        q_rd      = r_q_tab[r_ord];
        g_rd      = r_g_tab[r_ord];
        scan_hit  = (q_rd >= slpo_pkg::QUO_W'(r_cstar)) && (g_rd < r_best_g);
        scan_pick = scan_hit ? r_ord : r_best_o;
        n_cstar   = (r_maxq < slpo_pkg::QUO_W'(r_count0))
                  ? slpo_pkg::OBJS_W'(r_maxq) : r_count0;
        fall_ok   = r_m_found && ((r_m <= r_max_order)
                  || ({1'b0, r_m} < (slpo_pkg::ORD_W+1)'(slpo_pkg::ORDER_LIMIT)));
        dir_ok    = (dir_rsp.order <= slpo_pkg::HB_W'(r_max_order))
                  || (dir_rsp.order < slpo_pkg::HB_W'(slpo_pkg::ORDER_LIMIT));
    end

    slpo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    slpo_direct u_direct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dir_req),
        .o_rsp   (dir_rsp)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_order <= '0;
            r_max_order <= slpo_pkg::ORD_W'(3);
            r_min_objs  <= '0;
            r_cpu_count <= slpo_pkg::CPU_W'(4);
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                slpo_pkg::REG_MIN_ORDER: r_min_order <= i_cfg_data[slpo_pkg::ORD_W-1:0];
                slpo_pkg::REG_MAX_ORDER: r_max_order <= i_cfg_data[slpo_pkg::ORD_W-1:0];
                slpo_pkg::REG_MIN_OBJS:  r_min_objs  <= i_cfg_data[slpo_pkg::OBJS_W-1:0];
                slpo_pkg::REG_CPU_COUNT: r_cpu_count <= i_cfg_data[slpo_pkg::CPU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_dir_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_dir_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_size    <= in_size;
                        r_res     <= in_res;
                        r_count0  <= count0;
                        r_ord     <= first_ord;
                        r_end     <= last_ord;
                        r_dir     <= 1'b0;
                        r_maxq    <= '0;
                        r_m_found <= 1'b0;
                        r_m       <= '0;
                        if (in_size == '0) begin
                            r_res_order <= '0;
                            r_res_nofit <= 1'b1;
                            r_state     <= S_DONE;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (r_ord == r_min_order) begin
                            r_dir <= div_rsp.quo
                                   > slpo_pkg::QUO_W'(slpo_pkg::MAX_OBJECTS_PER_SLAB);
                        end
                        if (in_main && grade != slpo_pkg::GRADE_ANY
                                && div_rsp.quo > r_maxq) begin
                            r_maxq <= div_rsp.quo;
                        end
                        if (r_ord >= r_min_order && div_rsp.quo != '0 && !r_m_found) begin
                            r_m_found <= 1'b1;
                            r_m       <= r_ord;
                        end
                        if (r_ord == r_end) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_ord       <= r_ord + slpo_pkg::ORD_W'(1);
                            r_div_start <= 1'b1;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_dir) begin
                        r_dir_start <= 1'b1;
                        r_state     <= S_DIRECT;
                    end else if (n_cstar >= slpo_pkg::OBJS_W'(2)) begin
                        r_cstar  <= n_cstar;
                        r_ord    <= r_min_order;
                        r_best_g <= slpo_pkg::GRADE_ANY;
                        r_best_o <= r_min_order;
                        r_state  <= S_SCAN;
                    end else begin
                        r_res_order <= fall_ok ? r_m : '0;
                        r_res_nofit <= !fall_ok;
                        r_state     <= S_DONE;
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_best_g <= g_rd;
                        r_best_o <= r_ord;
                    end
                    if (r_ord == r_max_order) begin
                        r_res_order <= scan_pick;
                        r_res_nofit <= 1'b0;
                        r_state     <= S_DONE;
                    end else begin
                        r_ord <= r_ord + slpo_pkg::ORD_W'(1);
                    end
                end
                S_DIRECT: begin
                    if (dir_rsp.done) begin
                        r_res_order <= dir_ok ? slpo_pkg::ORD_W'(dir_rsp.order) : '0;
                        r_res_nofit <= !dir_ok;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // per-order capacity and waste grade
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_rsp.done) begin
            r_q_tab[r_ord] <= div_rsp.quo;
            r_g_tab[r_ord] <= grade;
        end
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_order <= r_res_order;
            r_out_nofit <= r_res_nofit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = slpo_pkg::OUT_TDATA_W'(r_out_order);
    assign m_axis_tuser  = r_out_nofit;

    a_nofit_order_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_out_order == '0))
        else $error("no-fit result carries a nonzero order");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!div_rsp.busy && !dir_rsp.busy))
        else $error("request taken while a unit is still busy");

endmodule

// ----- tb/sv/slab_page_order_select_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for slab_page_order_select: drives requests and register writes,
// predicts each page order and no-fit flag, checks them in order; needs slpo_pkg and the rtl
module slab_page_order_select_test;
    import slpo_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam longint unsigned OBJ_CAP = MAX_OBJECTS_PER_SLAB;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // object_bytes [23:0], reserved_bytes [35:24]
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // page_order [3:0]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // no_fit [0]
    logic                   m_axis_tuser;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    t_cfg_addr              i_cfg_addr    = REG_MIN_ORDER;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic             no_fit;
    } t_verdict;

    class page_order_board;
        logic [ORD_W-1:0]  min_order = 4'd0;
        logic [ORD_W-1:0]  max_order = 4'd3;
        logic [OBJS_W-1:0] min_objs  = 8'd0;
        logic [CPU_W-1:0]  cpus      = 13'd4;
        t_verdict          owed_orders[$];
        int                errors    = 0;
        int                checked   = 0;
        int                misfits   = 0;

        function int top_bit(longint unsigned x);
            int n = 0;
            while (x != 0) begin
                n++;
                x >>= 1;
            end
            return n;
        endfunction

        function int pages_order(longint unsigned bytes);
            if (bytes == 0) return 0;
            return top_bit((bytes - 1) >> PAGE_BITS);
        endfunction

        function longint unsigned slab_len(int order);
            longint unsigned one = 1;
            return (one << PAGE_BITS) << order;
        endfunction

        function longint unsigned objs_fitting(int order, longint unsigned size,
                                               longint unsigned rsv);
            longint unsigned s = slab_len(order);
            if (rsv > s) return 0;
            return (s - rsv) / size;
        endfunction

        // a value above top means no order fits
        function int try_orders(longint unsigned size, longint unsigned count, int top,
                                longint unsigned fract, longint unsigned rsv);
            int lo = int'(min_order);
            int ord;
            int first;
            int d;
            longint unsigned s;
            if (objs_fitting(lo, size, rsv) > OBJ_CAP) begin
                d = pages_order(size * OBJ_CAP) - 1;
                return (d < 0) ? 0 : d;
            end
            first = pages_order(count * size);
            if (first < lo) first = lo;
            for (ord = first; ord <= top; ord++) begin
                s = slab_len(ord);
                if (s < count * size + rsv) continue;
                if ((s - rsv) % size <= s / fract) break;
            end
            return ord;
        endfunction

        function t_verdict order_for(logic [OBJ_W-1:0] obj, logic [RES_W-1:0] rsv_in);
            longint unsigned size = obj;
            longint unsigned rsv  = rsv_in;
            longint unsigned need;
            longint unsigned most;
            longint unsigned fract;
            int              top  = int'(max_order);
            int              ord;
            t_verdict        v;
            v.order  = '0;
            v.no_fit = 1'b1;
            if (size == 0) return v;
            need = min_objs;
            if (need == 0) need = 4 * (top_bit(cpus) + 1);
            most = objs_fitting(top, size, rsv);
            if (most < need) need = most;
            while (need > 1) begin
                for (fract = 16; fract >= 4; fract /= 2) begin
                    ord = try_orders(size, need, top, fract, rsv);
                    if (ord <= top) begin
                        v.order  = ord[ORD_W-1:0];
                        v.no_fit = 1'b0;
                        return v;
                    end
                end
                need--;
            end
            // single object, any waste
            ord = try_orders(size, 1, top, 1, rsv);
            if (ord <= top) begin
                v.order  = ord[ORD_W-1:0];
                v.no_fit = 1'b0;
                return v;
            end
            ord = try_orders(size, 1, ORDER_LIMIT, 1, rsv);
            if (ord < ORDER_LIMIT) begin
                v.order  = ord[ORD_W-1:0];
                v.no_fit = 1'b0;
            end
            return v;
        endfunction

        function void write_reg(t_cfg_addr idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MIN_ORDER: min_order = val[ORD_W-1:0];
                REG_MAX_ORDER: max_order = val[ORD_W-1:0];
                REG_MIN_OBJS:  min_objs  = val[OBJS_W-1:0];
                REG_CPU_COUNT: cpus      = val[CPU_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [OBJ_W-1:0] obj, logic [RES_W-1:0] rsv);
            owed_orders.push_back(order_for(obj, rsv));
        endfunction

        function void check_result(logic [ORD_W-1:0] order, logic no_fit);
            t_verdict want;
            if (owed_orders.size() == 0) begin
                $error("result with no request outstanding: page_order %0d no_fit %0d",
                       order, no_fit);
                errors++;
                return;
            end
            want = owed_orders.pop_front();
            checked++;
            if (want.no_fit) misfits++;
            if (order !== want.order) begin
                $error("page_order expected %0d actual %0d", want.order, order);
                errors++;
            end
            if (no_fit !== want.no_fit) begin
                $error("no_fit expected %0d actual %0d", want.no_fit, no_fit);
                errors++;
            end
        endfunction

        function int pending();
            return owed_orders.size();
        endfunction
    endclass

    page_order_board board = new();
    bit              calm       = 1'b0;
    int unsigned     stall_left = 0;
    int unsigned     cycles     = 0;
    int              settings   = 1;

    slab_page_order_select u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) board.write_reg(i_cfg_addr, i_cfg_data);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata[ORD_W-1:0], m_axis_tuser);
            if (s_axis_tvalid && s_axis_tready)
                board.note_request(s_axis_tdata[OBJ_W-1:0],
                                   s_axis_tdata[OBJ_W+RES_W-1:OBJ_W]);
        end
    end

    task automatic send_request(input logic [OBJ_W-1:0] obj, input logic [RES_W-1:0] rsv);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= IN_TDATA_W'({rsv, obj});
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(input logic [ORD_W-1:0] lo, input logic [ORD_W-1:0] hi,
                              input logic [OBJS_W-1:0] objs, input logic [CPU_W-1:0] cpus);
        write_reg(REG_MIN_ORDER, CFG_DATA_W'(lo));
        write_reg(REG_MAX_ORDER, CFG_DATA_W'(hi));
        write_reg(REG_MIN_OBJS, CFG_DATA_W'(objs));
        write_reg(REG_CPU_COUNT, CFG_DATA_W'(cpus));
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [OBJ_W-1:0]  obj;
        logic [RES_W-1:0]  rsv;
        logic [ORD_W-1:0]  lo;
        logic [ORD_W-1:0]  hi;
        logic [OBJS_W-1:0] objs;
        logic [CPU_W-1:0]  cpus;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: zero size, page edges, largest sizes, full reserve
        send_request(24'd0, 12'd0);
        send_request(24'd1, 12'd0);
        send_request(24'd8, 12'd4095);
        send_request(24'd700, 12'd100);
        send_request(24'd4096, 12'd0);
        send_request(24'd4097, 12'd0);
        send_request(24'd32768, 12'd0);
        send_request(24'd65536, 12'd0);
        send_request(24'd3000, 12'd4095);
        send_request(24'd8388608, 12'd0);
        send_request(24'hFFFFFF, 12'd4095);

        // objects of one and two bytes at a high start order take the direct order
        wait_idle();
        set_config(4'd4, 4'd6, 8'd0, 13'd0);
        send_request(24'd1, 12'd0);
        send_request(24'd2, 12'd0);
        send_request(24'd24, 12'd17);

        // start order above the top order
        wait_idle();
        set_config(4'd5, 4'd1, 8'd3, 13'd2);
        send_request(24'd64, 12'd0);
        send_request(24'd5000, 12'd0);

        wait_idle();
        set_config(4'd15, 4'd15, 8'd255, 13'd8191);
        send_request(24'd1, 12'd0);
        send_request(24'd1000, 12'd4095);
        send_request(24'd8388608, 12'd0);

        // one-page ceiling, fallback past the top order
        wait_idle();
        set_config(4'd0, 4'd0, 8'd1, 13'd1);
        send_request(24'd4096, 12'd0);
        send_request(24'd4096, 12'd1);
        send_request(24'd2049, 12'd0);
        send_request(24'd9000, 12'd0);

        for (int p = 0; p < 12; p++) begin
            case (p)
                0: begin lo = 4'd0;  hi = 4'd11; objs = 8'd0;   cpus = 13'd4096; end
                1: begin lo = 4'd11; hi = 4'd11; objs = 8'd255; cpus = 13'd1;    end
                2: begin lo = 4'd0;  hi = 4'd0;  objs = 8'd255; cpus = 13'd0;    end
                default: begin
                    lo   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(0, 3));
                    hi   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(1, 6));
                    objs = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom());
                    cpus = ($urandom_range(0, 1) == 0) ? 13'($urandom())
                                                       : 13'($urandom_range(1, 64));
                end
            endcase
            wait_idle();
            set_config(lo, hi, objs, cpus);
            calm = (p == 11);
            for (int i = 0; i < 160; i++) begin
                case ($urandom_range(0, 9))
                    0:       obj = 24'($urandom_range(1, 64));
                    1, 2:    obj = 24'($urandom_range(1, 512));
                    3, 4:    obj = 24'($urandom_range(513, 4096));
                    5:       obj = 24'($urandom_range(4097, 65536));
                    6:       obj = 24'($urandom_range(65537, 8388608));
                    7:       obj = 24'($urandom());
                    8:       obj = 24'((1 << $urandom_range(0, 23)) + $urandom_range(0, 1));
                    default: obj = ($urandom_range(0, 19) == 0)
                                   ? 24'd0 : 24'($urandom_range(1, 2048) * 8);
                endcase
                case ($urandom_range(0, 3))
                    0, 1:    rsv = 12'd0;
                    2:       rsv = 12'($urandom_range(0, 255));
                    default: rsv = 12'($urandom());
                endcase
                if (p == 4 && i == 80) wait_idle();
                send_request(obj, rsv);
            end
        end

        wait_idle();
        repeat (600) @(posedge i_clk);
        $display("%0d requests checked over %0d register settings, %0d without a fitting order",
                 board.checked, settings, board.misfits);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/slpo_pkg.sv
src/slpo_div.sv
src/slpo_direct.sv
src/slab_page_order_select.sv
tb/sv/slab_page_order_select_test.sv
